### design/ray_aabb_slab_test_assert.svh
// assertion macros for the ray box slab test checker
`ifndef RAY_AABB_SLAB_TEST_ASSERT_SVH
`define RAY_AABB_SLAB_TEST_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RAABB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RAABB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define RAABB_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/raabb_pkg.sv
// ----------------------------------------------------------------------------
// raabb_pkg
// shared types, constants and helpers of the ray box slab test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package raabb_pkg;

  localparam int QBITS = 32;
  localparam int NAXES = 3;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // one divider lane: partial remainder, dividend/quotient shift word, divisor, sign and overflow flags
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] sh;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
  } raabb_lane_t;

  // per-axis flags that ride beside the dividers
  typedef struct packed {
    logic dzero;
    logic in_slab;
  } raabb_side_t;

  // set up a divide of (off * 2^16) / d on magnitudes
  function automatic raabb_lane_t make_lane(input logic signed [34:0] off,
                                            input logic signed [31:0] d);
    raabb_lane_t l;
    logic [34:0] offm;
    logic [31:0] dm;
    logic [50:0] num;
    offm = off[34] ? 35'(-off) : 35'(off);
    dm   = d[31] ? 32'(-d) : 32'(d);
    num  = {offm, 16'b0};
    l.neg = off[34] ^ d[31];
    l.ovf = ({13'b0, num} >= {dm, 32'b0});
    l.rem = {13'b0, num[50:32]};
    l.sh  = num[31:0];
    l.den = dm;
    return l;
  endfunction

  // signed, saturated distance from a finished lane
  function automatic logic signed [31:0] lane_dist(input raabb_lane_t l);
    logic signed [31:0] r;
    if (l.ovf) begin
      r = l.neg ? Q_MIN : Q_MAX;
    end else if (l.neg) begin
      r = (l.sh > 32'h8000_0000) ? Q_MIN : $signed(32'(-l.sh));
    end else begin
      r = l.sh[31] ? Q_MAX : $signed(l.sh);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/ray_aabb_slab_test.sv
// ----------------------------------------------------------------------------
// ray_aabb_slab_test
// ray against axis-aligned box, slab test, signed q16.16, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  in_*     | in  | ray origin, direction, box center, half extents
//  out_*    | out | hit flag and saturated entry distance
//
//  one beat accepted per cycle unless stalled; the pipe is 2 setup stages,
//  32 divider stages (one quotient bit each, six lanes in parallel), 2 reduce
//  stages; the divider stage chain sets the depth
//  rst_n clears only the valid bits; payload registers are not reset
//  a stall at out_tready freezes the whole pipe; in_tready drops with it
// ----------------------------------------------------------------------------
`default_nettype none

module ray_aabb_slab_test
  import raabb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
  // center_z (32 bits each), extent_x, extent_y, extent_z (30 bits each), pad
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // hit (1), near_distance (32), pad
  output logic [39:0]       out_tdata
);

  localparam int NSTG = 2 + QBITS + 2;

  logic              en;
  logic [NSTG-1:0]   vld_r;
  logic              hit;
  logic signed [31:0] near_distance;

  // per-stage divider lanes and side flags
  raabb_lane_t lane_lo_w [QBITS+1][NAXES];
  raabb_lane_t lane_hi_w [QBITS+1][NAXES];
  raabb_side_t side_r    [QBITS+1][NAXES];
  raabb_lane_t lane_lo_f [NAXES];
  raabb_lane_t lane_hi_f [NAXES];
  raabb_side_t side_f    [NAXES];

  // advance when the output slot is empty or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  genvar a, s;
  generate
    for (a = 0; a < NAXES; a++) begin : g_axis
      raabb_prep u_prep (
        .clk     (clk),
        .en      (en),
        .org     ($signed(in_tdata[32*a +: 32])),
        .dir     ($signed(in_tdata[96 + 32*a +: 32])),
        .ctr     ($signed(in_tdata[192 + 32*a +: 32])),
        .ext     (in_tdata[288 + 30*a +: 30]),
        .lane_lo (lane_lo_w[0][a]),
        .lane_hi (lane_hi_w[0][a]),
        .side    (side_r[0][a])
      );

      for (s = 0; s < QBITS; s++) begin : g_stage
        raabb_div_step u_lo (
          .clk(clk), .en(en), .lane_i(lane_lo_w[s][a]), .lane_o(lane_lo_w[s+1][a])
        );
        raabb_div_step u_hi (
          .clk(clk), .en(en), .lane_i(lane_hi_w[s][a]), .lane_o(lane_hi_w[s+1][a])
        );
        // side flags keep pace with the divider stages
        always_ff @(posedge clk) begin
          if (en) begin
            side_r[s+1][a] <= side_r[s][a];
          end
        end
      end

      assign lane_lo_f[a] = lane_lo_w[QBITS][a];
      assign lane_hi_f[a] = lane_hi_w[QBITS][a];
      assign side_f[a]    = side_r[QBITS][a];
    end
  endgenerate

  raabb_reduce u_reduce (
    .clk           (clk),
    .en            (en),
    .lane_lo       (lane_lo_f),
    .lane_hi       (lane_hi_f),
    .side          (side_f),
    .hit           (hit),
    .near_distance (near_distance)
  );

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {7'b0, near_distance, hit};

endmodule

`default_nettype wire

### design/raabb_prep.sv
// ----------------------------------------------------------------------------
// raabb_prep
// two stages per axis: slab planes and offsets, then divider setup
// ----------------------------------------------------------------------------
`default_nettype none

module raabb_prep
  import raabb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] org,
  input  wire logic signed [31:0] dir,
  input  wire logic signed [31:0] ctr,
  input  wire logic        [29:0] ext,
  output raabb_lane_t             lane_lo,
  output raabb_lane_t             lane_hi,
  output raabb_side_t             side
);

  logic signed [33:0] lo, hi, org34;
  logic signed [34:0] off_lo_nxt, off_hi_nxt;
  logic signed [34:0] off_lo_r, off_hi_r;
  logic signed [31:0] dir_r;
  raabb_side_t        side_a_nxt, side_a_r, side_b_r;
  raabb_lane_t        lane_lo_r, lane_hi_r;

  always_comb begin
    org34 = {{2{org[31]}}, org};
    lo    = {{2{ctr[31]}}, ctr} - $signed({4'b0, ext});
    hi    = {{2{ctr[31]}}, ctr} + $signed({4'b0, ext});
    off_lo_nxt = {lo[33], lo} - {org34[33], org34};
    off_hi_nxt = {hi[33], hi} - {org34[33], org34};
    side_a_nxt.dzero   = (dir == 32'sd0);
    side_a_nxt.in_slab = (org34 >= lo) && (org34 <= hi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_lo_r  <= off_lo_nxt;
      off_hi_r  <= off_hi_nxt;
      dir_r     <= dir;
      side_a_r  <= side_a_nxt;
      lane_lo_r <= make_lane(off_lo_r, dir_r);
      lane_hi_r <= make_lane(off_hi_r, dir_r);
      side_b_r  <= side_a_r;
    end
  end

  assign lane_lo = lane_lo_r;
  assign lane_hi = lane_hi_r;
  assign side    = side_b_r;

endmodule

`default_nettype wire

### design/raabb_div_step.sv
// ----------------------------------------------------------------------------
// raabb_div_step
// one restoring-division stage: while en is high, one quotient bit per lane per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module raabb_div_step
  import raabb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire raabb_lane_t lane_i,
  output raabb_lane_t      lane_o
);

  logic [32:0] rem2, diff;
  logic        qbit;
  raabb_lane_t lane_nxt, lane_r;

  always_comb begin
    rem2     = {lane_i.rem, lane_i.sh[31]};
    diff     = rem2 - {1'b0, lane_i.den};
    qbit     = !diff[32];
    lane_nxt = lane_i;
    lane_nxt.rem = qbit ? diff[31:0] : rem2[31:0];
    lane_nxt.sh  = {lane_i.sh[30:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

### design/raabb_reduce.sv
// ----------------------------------------------------------------------------
// raabb_reduce
// saturate quotients, order entry/exit per axis, then near/far and hit
// ----------------------------------------------------------------------------
`default_nettype none

module raabb_reduce
  import raabb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire raabb_lane_t        lane_lo [NAXES],
  input  wire raabb_lane_t        lane_hi [NAXES],
  input  wire raabb_side_t        side    [NAXES],
  output logic                    hit,
  output logic signed [31:0]      near_distance
);

  logic signed [31:0] ent_nxt [NAXES];
  logic signed [31:0] exi_nxt [NAXES];
  logic               ok_nxt  [NAXES];
  logic signed [31:0] ent_r   [NAXES];
  logic signed [31:0] exi_r   [NAXES];
  logic               ok_r    [NAXES];
  logic signed [31:0] nearv, farv;
  logic               hit_nxt, hit_r;
  logic signed [31:0] near_r;

  always_comb begin
    for (int a = 0; a < NAXES; a++) begin
      logic signed [31:0] t1, t2;
      t1 = lane_dist(lane_lo[a]);
      t2 = lane_dist(lane_hi[a]);
      if (side[a].dzero) begin
        ent_nxt[a] = Q_MIN;
        exi_nxt[a] = Q_MAX;
        ok_nxt[a]  = side[a].in_slab;
      end else begin
        ent_nxt[a] = (t1 < t2) ? t1 : t2;
        exi_nxt[a] = (t1 < t2) ? t2 : t1;
        ok_nxt[a]  = 1'b1;
      end
    end
  end

  always_comb begin
    nearv = Q_MIN;
    farv  = Q_MAX;
    for (int a = 0; a < NAXES; a++) begin
      if (ent_r[a] > nearv) nearv = ent_r[a];
      if (exi_r[a] < farv)  farv  = exi_r[a];
    end
    hit_nxt = ok_r[0] && ok_r[1] && ok_r[2] && !(nearv > farv) && !farv[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r  <= ent_nxt;
      exi_r  <= exi_nxt;
      ok_r   <= ok_nxt;
      hit_r  <= hit_nxt;
      near_r <= hit_nxt ? nearv : 32'sd0;
    end
  end

  assign hit           = hit_r;
  assign near_distance = near_r;

endmodule

`default_nettype wire

### design/ray_aabb_slab_test_chk.sv
// ----------------------------------------------------------------------------
// ray_aabb_slab_test_chk
// port-level checks on the slab test, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_aabb_slab_test_assert.svh"

module ray_aabb_slab_test_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [383:0] in_tdata,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [39:0]  out_tdata
);

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

  `RAABB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled output beat changed")
  `RAABB_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[32:1] == 32'h0, "miss with nonzero distance")
  `RAABB_ASSERT_NOW(a_ready_free, !out_tvalid || out_tready, in_tready, "input stalled with free output slot")
  `RAABB_ASSERT_ALWAYS(a_reset_clear, !rst_n, !out_tvalid, "output valid right after reset")

endmodule

bind ray_aabb_slab_test ray_aabb_slab_test_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
